@@ sv/byte_signal_analog_classifier_defines.svh @@
// Assertion macros shared by the analog classifier RTL.
`ifndef BYTE_SIGNAL_ANALOG_CLASSIFIER_DEFINES_SVH
`define BYTE_SIGNAL_ANALOG_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define BSAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define BSAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BSAC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BSAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/bsac_pkg.sv @@
// Widths, register indexes and reset values of the analog classifier.
package bsac_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int COUNT_W    = 10;
	localparam int CHANGE_W   = 8;
	localparam int DISTINCT_W = 9;
	localparam int POS_W      = 3;
	localparam int INDEX_W    = 3;
	localparam int CFG_DATA_W = 10;
	localparam int VALUES     = 256;

	localparam logic [COUNT_W-1:0]  COUNT_MAX      = 10'd1023;
	localparam logic [CHANGE_W-1:0] CHANGE_MAX     = 8'd255;
	localparam logic [POS_W-1:0]    POSITION_LIMIT = 3'd6;

	// Register indexes
	localparam logic [INDEX_W-1:0] REG_BYTE_POSITION     = 3'd0;
	localparam logic [INDEX_W-1:0] REG_MIN_SAMPLES       = 3'd1;
	localparam logic [INDEX_W-1:0] REG_BIG_STEP          = 3'd2;
	localparam logic [INDEX_W-1:0] REG_MAX_BIG_CHANGES   = 3'd3;
	localparam logic [INDEX_W-1:0] REG_MIN_SMALL_CHANGES = 3'd4;
	localparam logic [INDEX_W-1:0] REG_MIN_DISTINCT      = 3'd5;
	localparam logic [INDEX_W-1:0] REG_MIN_RANGE         = 3'd6;

	// Register reset values
	localparam logic [POS_W-1:0]      RST_BYTE_POSITION     = 3'd0;
	localparam logic [COUNT_W-1:0]    RST_MIN_SAMPLES       = 10'd100;
	localparam logic [SAMPLE_W-1:0]   RST_BIG_STEP          = 8'd50;
	localparam logic [CHANGE_W-1:0]   RST_MAX_BIG_CHANGES   = 8'd10;
	localparam logic [CHANGE_W-1:0]   RST_MIN_SMALL_CHANGES = 8'd50;
	localparam logic [DISTINCT_W-1:0] RST_MIN_DISTINCT      = 9'd3;
	localparam logic [SAMPLE_W-1:0]   RST_MIN_RANGE         = 8'd10;

endpackage

@@ sv/bsac_if.sv @@
// Valid/ready stream interfaces for samples and verdicts.
interface bsac_in_if;
	logic                          valid;
	logic                          ready;
	logic [bsac_pkg::SAMPLE_W-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface bsac_out_if;
	logic                            valid;
	logic                            ready;
	logic                            analog_flag;
	logic [bsac_pkg::SAMPLE_W-1:0]   value_spread;
	logic [bsac_pkg::DISTINCT_W-1:0] distinct_values;

	modport source (output valid, output analog_flag, output value_spread,
		output distinct_values, input ready);
	modport sink (input valid, input analog_flag, input value_spread,
		input distinct_values, output ready);
endinterface

@@ sv/byte_signal_analog_classifier.sv @@
// Analog-signal classifier for one byte position of a sample sequence.
//
//  channel   | role   | handshake    | payload
//  ----------+--------+--------------+-------------------------------------------
//  samples   | sink   | valid/ready  | sample[7:0], last
//  verdicts  | source | valid/ready  | analog_flag, value_spread[7:0], distinct_values[8:0]
//  cfg_*     | write  | cfg_we       | cfg_index[2:0], cfg_data[9:0]
//
// One sample is taken every cycle unless a final sample waits in the input register;
// a verdict is offered from the result register once its final sample leaves the input register.
// Reset clears all counters and the 256-entry seen map at once; no clearing pass.
// A final sample waits in the input register only while an untaken verdict
// occupies the result register; other samples never wait on the verdict side.
`include "byte_signal_analog_classifier_defines.svh"

module byte_signal_analog_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	bsac_in_if.sink                           samples,
	bsac_out_if.source                        verdicts,
	input  logic                              cfg_we,
	input  logic [bsac_pkg::INDEX_W-1:0]      cfg_index,
	input  logic [bsac_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SW = bsac_pkg::SAMPLE_W;
	localparam int CW = bsac_pkg::COUNT_W;
	localparam int HW = bsac_pkg::CHANGE_W;
	localparam int DW = bsac_pkg::DISTINCT_W;

	// configuration registers
	logic [bsac_pkg::POS_W-1:0] byte_position_q;
	logic [CW-1:0]              min_samples_q;
	logic [SW-1:0]              big_step_q;
	logic [HW-1:0]              max_big_q;
	logic [HW-1:0]              min_small_q;
	logic [DW-1:0]              min_distinct_q;
	logic [SW-1:0]              min_range_q;

	// input stage
	logic          valid_s1;
	logic [SW-1:0] sample_s1;
	logic          last_s1;

	// sequence state
	logic                        have_prev_q;
	logic [SW-1:0]               prev_q;
	logic [SW-1:0]               low_q;
	logic [SW-1:0]               high_q;
	logic [CW-1:0]               scount_q;
	logic [HW-1:0]               big_q;
	logic [HW-1:0]               small_q;
	logic [bsac_pkg::VALUES-1:0] seen_q;
	logic [DW-1:0]               distinct_q;

	// result register
	logic          out_valid_q;
	logic          analog_flag_q;
	logic [SW-1:0] spread_q;
	logic [DW-1:0] distinct_out_q;

	logic          out_free;
	logic          advance_s1;
	logic [SW-1:0] diff;
	logic          is_big;
	logic          is_small;
	logic [CW-1:0] scount_next;
	logic [HW-1:0] big_next;
	logic [HW-1:0] small_next;
	logic [SW-1:0] spread;
	logic          verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= bsac_pkg::RST_BYTE_POSITION;
			min_samples_q   <= bsac_pkg::RST_MIN_SAMPLES;
			big_step_q      <= bsac_pkg::RST_BIG_STEP;
			max_big_q       <= bsac_pkg::RST_MAX_BIG_CHANGES;
			min_small_q     <= bsac_pkg::RST_MIN_SMALL_CHANGES;
			min_distinct_q  <= bsac_pkg::RST_MIN_DISTINCT;
			min_range_q     <= bsac_pkg::RST_MIN_RANGE;
		end else if (cfg_we) begin
			case (cfg_index)
				bsac_pkg::REG_BYTE_POSITION:     byte_position_q <= cfg_data[bsac_pkg::POS_W-1:0];
				bsac_pkg::REG_MIN_SAMPLES:       min_samples_q   <= cfg_data[CW-1:0];
				bsac_pkg::REG_BIG_STEP:          big_step_q      <= cfg_data[SW-1:0];
				bsac_pkg::REG_MAX_BIG_CHANGES:   max_big_q       <= cfg_data[HW-1:0];
				bsac_pkg::REG_MIN_SMALL_CHANGES: min_small_q     <= cfg_data[HW-1:0];
				bsac_pkg::REG_MIN_DISTINCT:      min_distinct_q  <= cfg_data[DW-1:0];
				bsac_pkg::REG_MIN_RANGE:         min_range_q     <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// a final sample needs the result register; others always advance
	assign out_free      = !out_valid_q || verdicts.ready;
	assign advance_s1    = valid_s1 && (!last_s1 || out_free);
	assign samples.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample;
			last_s1   <= samples.last;
		end
	end

	always_comb begin
		diff        = (prev_q > sample_s1) ? prev_q - sample_s1 : sample_s1 - prev_q;
		is_big      = have_prev_q && (diff > big_step_q);
		is_small    = have_prev_q && !(diff > big_step_q) && (diff != '0);
		scount_next = (scount_q != bsac_pkg::COUNT_MAX) ? scount_q + 1'b1 : scount_q;
		big_next    = (is_big && big_q != bsac_pkg::CHANGE_MAX) ? big_q + 1'b1 : big_q;
		small_next  = (is_small && small_q != bsac_pkg::CHANGE_MAX) ? small_q + 1'b1 : small_q;
		// the final sample never enters the range; a sequence of only a final sample has zero spread
		spread      = have_prev_q ? high_q - low_q : '0;
		verdict     = (scount_next >= min_samples_q)
			&& (byte_position_q < bsac_pkg::POSITION_LIMIT)
			&& (big_next <= max_big_q)
			&& (small_next >= min_small_q)
			&& (distinct_q >= min_distinct_q)
			&& (spread >= min_range_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			low_q       <= '0;
			high_q      <= '0;
			scount_q    <= '0;
			big_q       <= '0;
			small_q     <= '0;
			seen_q      <= '0;
			distinct_q  <= '0;
		end else if (advance_s1) begin
			if (last_s1) begin
				have_prev_q <= 1'b0;
				prev_q      <= '0;
				low_q       <= '0;
				high_q      <= '0;
				scount_q    <= '0;
				big_q       <= '0;
				small_q     <= '0;
				seen_q      <= '0;
				distinct_q  <= '0;
			end else begin
				have_prev_q       <= 1'b1;
				prev_q            <= sample_s1;
				scount_q          <= scount_next;
				big_q             <= big_next;
				small_q           <= small_next;
				seen_q[sample_s1] <= 1'b1;
				if (!seen_q[sample_s1]) begin
					distinct_q <= distinct_q + 1'b1;
				end
				if (!have_prev_q || sample_s1 < low_q) begin
					low_q <= sample_s1;
				end
				if (!have_prev_q || sample_s1 > high_q) begin
					high_q <= sample_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			analog_flag_q  <= verdict;
			spread_q       <= spread;
			distinct_out_q <= distinct_q;
		end
	end

	assign verdicts.valid           = out_valid_q;
	assign verdicts.analog_flag     = analog_flag_q;
	assign verdicts.value_spread    = spread_q;
	assign verdicts.distinct_values = distinct_out_q;

	`BSAC_ASSERT_SAME(a_distinct_matches_map, clk, arst_n, 1'b1,
		distinct_q == DW'($countones(seen_q)))
	`BSAC_ASSERT_SAME(a_empty_sequence_no_values, clk, arst_n, !have_prev_q,
		distinct_q == '0 && seen_q == '0)
	`BSAC_ASSERT_NEXT(a_final_clears_state, clk, arst_n, advance_s1 && last_s1,
		!have_prev_q && scount_q == '0 && big_q == '0 && small_q == '0 && out_valid_q)
	`BSAC_ASSERT_NEXT(a_blocked_final_holds, clk, arst_n, valid_s1 && last_s1 && !out_free,
		valid_s1 && last_s1 && out_valid_q)

endmodule
